FILE: src/iaj_pkg.sv
// iaj_pkg: shared types, codes and constant-division helpers for the
// interarrival jitter estimator. No dependencies.

package iaj_pkg;

   // Packet event modes
   typedef enum logic [1:0] {
      MODE_OBSERVE  = 2'd0,
      MODE_REANCHOR = 2'd1,
      MODE_CLEAR    = 2'd2
   } mode_type;

   // What the statistics stage does with an item
   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_DIFF  = 2'd1,
      ACT_CLEAR = 2'd2
   } act_type;

   // Configuration
   localparam int unsigned ADDR_W    = 3;
   localparam int unsigned DATA_W    = 32;
   localparam logic [3:0]  GAIN_RST  = 4'd4;
   localparam logic        REG_GAIN  = 1'b0;   // word index bit of gain_shift

   // Digit-serial constant division: 16-bit digits, reciprocal multiply
   localparam int unsigned DIGIT_W      = 16;
   localparam int unsigned NUM_DIGITS   = 4;
   localparam logic [6:0]  DIV125       = 7'd125;
   localparam logic [23:0] DIV125_RECIP = 24'd8589935;   // ceil(2^30 / 125)
   localparam int unsigned DIV125_SHIFT = 30;
   localparam logic [1:0]  DIV3         = 2'd3;
   localparam logic [18:0] DIV3_RECIP   = 19'd349526;    // ceil(2^20 / 3)
   localparam int unsigned DIV3_SHIFT   = 20;

   // Transit difference saturation bound, 2^47 - 1
   localparam logic signed [49:0] DIFF_HI = 50'sd140737488355327;
   localparam logic signed [49:0] DIFF_LO = -50'sd140737488355327;

   // Input item
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] media_timestamp;
      logic [47:0] arrival_time_us;
   } req_type;

   // Result item
   typedef struct packed {
      logic               is_anchored;
      logic signed [47:0] last_transit_delta;
      logic [46:0]        peak_abs_delta;
      logic [62:0]        jitter_samples_q16;
      logic [61:0]        jitter_us_q8;
      logic [31:0]        sample_count;
   } rsp_type;

   // One division digit step results
   typedef struct packed {
      logic [15:0] quo;
      logic [6:0]  rem;
   } d125_type;

   typedef struct packed {
      logic [15:0] quo;
      logic [1:0]  rem;
   } d3_type;

   // Arrival conversion stages
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] ts;
      logic [63:0] word;
      logic [6:0]  rem;
   } cnv_stage_type;

   // Raw transit difference stage
   typedef struct packed {
      act_type            act;
      logic               anchored;
      logic signed [49:0] diff;
   } dlt_stage_type;

   // Saturated difference stage
   typedef struct packed {
      act_type            act;
      logic               anchored;
      logic signed [47:0] delta;
      logic [46:0]        mag;
   } sat_stage_type;

   // State snapshot carried to the output
   typedef struct packed {
      logic               anchored;
      logic signed [47:0] delta;
      logic [46:0]        peak;
      logic [62:0]        jitter;
      logic [31:0]        count;
   } stat_type;

   // Microsecond conversion stages
   typedef struct packed {
      stat_type    stat;
      logic [63:0] word;
      logic [1:0]  rem;
   } out_stage_type;

   // floor(({rem, chunk}) / 125) for rem < 125
   function automatic d125_type div125_step(input logic [6:0] rem,
                                            input logic [15:0] chunk);
      logic [22:0] num;
      logic [46:0] prod;
      logic [22:0] back;
      d125_type    res;
      num      = {rem, chunk};
      prod     = num * DIV125_RECIP;
      res.quo  = prod[DIV125_SHIFT +: DIGIT_W];
      back     = num - res.quo * DIV125;
      res.rem  = back[6:0];
      return res;
   endfunction

   // floor(({rem, chunk}) / 3) for rem < 3
   function automatic d3_type div3_step(input logic [1:0] rem,
                                        input logic [15:0] chunk);
      logic [17:0] num;
      logic [36:0] prod;
      logic [17:0] back;
      d3_type      res;
      num      = {rem, chunk};
      prod     = num * DIV3_RECIP;
      res.quo  = prod[DIV3_SHIFT +: DIGIT_W];
      back     = num - res.quo * DIV3;
      res.rem  = back[1:0];
      return res;
   endfunction

endpackage

FILE: src/interarrival_jitter_estimator.sv
// interarrival_jitter_estimator: top level, RFC 3550 style interarrival jitter
// with Q16 fixed-point averaging. Depends on iaj_pkg.

// Accepts one packet event per cycle while not stalled and returns one result
// item per event, showing the state after that event. Most of the pipeline
// depth comes from the two constant divisions: microseconds to 48 kHz samples
// (divide by 125) and the Q8 microsecond jitter (divide by 3 after a shift),
// each done as four 16-bit digit steps, one pipeline stage per digit. The
// stages advance independently, so bubbles close up and input is only stalled
// when every stage holds an item.
// gain_shift sits at byte address 0 and resets to 4; write it only while idle.
module interarrival_jitter_estimator
   import iaj_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   // result items
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   // configuration
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int unsigned STG_DLT  = NUM_DIGITS + 1;
   localparam int unsigned STG_SAT  = NUM_DIGITS + 2;
   localparam int unsigned STG_SNP  = NUM_DIGITS + 3;
   localparam int unsigned STG_OUT0 = NUM_DIGITS + 4;
   localparam int unsigned NSTG     = STG_OUT0 + NUM_DIGITS + 1;

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [3:0] gain_ff, gain_in;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      gain_in = gain_ff;
      if (csr_wr && paddr[2] == REG_GAIN) gain_in = pwdata[3:0];
   end

   assign prdata = (paddr[2] == REG_GAIN) ? {28'd0, gain_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) gain_ff <= GAIN_RST;
      else       gain_ff <= gain_in;
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: a stage takes an item when empty or draining
   // ---------------------------------------------------------------------
   logic [NSTG-1:0] valid_ff, ready, xfer;

   always_comb begin
      ready[NSTG-1] = !valid_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      xfer[0] = req_valid && ready[0];
      for (int k = 1; k < NSTG; k++) begin
         xfer[k] = valid_ff[k-1] && ready[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= req_valid;
         for (int k = 1; k < NSTG; k++) begin
            if (ready[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign req_stall = !ready[0];

   // ---------------------------------------------------------------------
   // Arrival conversion: x = 6 * us, then x / 125 one digit per stage
   // ---------------------------------------------------------------------
   cnv_stage_type cnv_ff [0:NUM_DIGITS];
   cnv_stage_type cnv_in [0:NUM_DIGITS];

   always_comb begin
      cnv_in[0].mode = req_data.mode;
      cnv_in[0].ts   = req_data.media_timestamp;
      cnv_in[0].word = {14'd0, req_data.arrival_time_us, 2'b00} +
                       {15'd0, req_data.arrival_time_us, 1'b0};
      cnv_in[0].rem  = '0;
   end

   always_ff @(posedge clock) begin
      if (xfer[0]) cnv_ff[0] <= cnv_in[0];
   end

   for (genvar j = 1; j <= NUM_DIGITS; j++) begin : g_cnv
      localparam int unsigned DIG = NUM_DIGITS - j;
      d125_type step;

      always_comb begin
         step   = div125_step(cnv_ff[j-1].rem, cnv_ff[j-1].word[DIG*DIGIT_W +: DIGIT_W]);
         cnv_in[j] = cnv_ff[j-1];
         cnv_in[j].word[DIG*DIGIT_W +: DIGIT_W] = step.quo;
         cnv_in[j].rem = step.rem;
      end

      always_ff @(posedge clock) begin
         if (xfer[j]) cnv_ff[j] <= cnv_in[j];
      end
   end

   // ---------------------------------------------------------------------
   // Reference tracking and raw transit difference
   // ---------------------------------------------------------------------
   logic          anchored_ff, anchored_in;
   logic [31:0]   ref_ts_ff, ref_ts_in;
   logic [47:0]   ref_smp_ff, ref_smp_in;
   dlt_stage_type dlt_ff, dlt_in;
   logic [47:0]        smp;
   logic signed [48:0] arr_delta;
   logic [31:0]        ts_diff;
   logic signed [31:0] ts_delta;

   always_comb begin
      smp       = cnv_ff[NUM_DIGITS].word[47:0];
      arr_delta = $signed({1'b0, smp}) - $signed({1'b0, ref_smp_ff});
      ts_diff   = cnv_ff[NUM_DIGITS].ts - ref_ts_ff;
      ts_delta  = $signed(ts_diff);

      anchored_in = anchored_ff;
      ref_ts_in   = ref_ts_ff;
      ref_smp_in  = ref_smp_ff;
      dlt_in.act  = ACT_NONE;
      dlt_in.diff = 50'(arr_delta) - 50'(ts_delta);

      unique case (cnv_ff[NUM_DIGITS].mode)
         MODE_OBSERVE: begin
            if (anchored_ff) dlt_in.act = ACT_DIFF;
            anchored_in = 1'b1;
            ref_ts_in   = cnv_ff[NUM_DIGITS].ts;
            ref_smp_in  = smp;
         end
         MODE_REANCHOR: begin
            anchored_in = 1'b1;
            ref_ts_in   = cnv_ff[NUM_DIGITS].ts;
            ref_smp_in  = smp;
         end
         MODE_CLEAR: begin
            dlt_in.act  = ACT_CLEAR;
            anchored_in = 1'b0;
            ref_ts_in   = '0;
            ref_smp_in  = '0;
         end
         default: begin
            // unused mode code: state untouched, result reported as usual
         end
      endcase
      dlt_in.anchored = anchored_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchored_ff <= 1'b0;
         ref_ts_ff   <= '0;
         ref_smp_ff  <= '0;
      end else if (xfer[STG_DLT]) begin
         anchored_ff <= anchored_in;
         ref_ts_ff   <= ref_ts_in;
         ref_smp_ff  <= ref_smp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer[STG_DLT]) dlt_ff <= dlt_in;
   end

   // ---------------------------------------------------------------------
   // Saturation to +-(2^47 - 1) and magnitude
   // ---------------------------------------------------------------------
   sat_stage_type      sat_ff, sat_in;
   logic signed [49:0] clamped;
   logic [47:0]        mag_w;

   always_comb begin
      priority if (dlt_ff.diff > DIFF_HI) clamped = DIFF_HI;
      else if (dlt_ff.diff < DIFF_LO)     clamped = DIFF_LO;
      else                                clamped = dlt_ff.diff;
      sat_in.act      = dlt_ff.act;
      sat_in.anchored = dlt_ff.anchored;
      sat_in.delta    = clamped[47:0];
      mag_w           = sat_in.delta[47] ? 48'(-sat_in.delta) : sat_in.delta;
      sat_in.mag      = mag_w[46:0];
   end

   always_ff @(posedge clock) begin
      if (xfer[STG_SAT]) sat_ff <= sat_in;
   end

   // ---------------------------------------------------------------------
   // Statistics: latest delta, peak, Q16 average, count
   // ---------------------------------------------------------------------
   logic signed [47:0] delta_ff, delta_in;
   logic [46:0]        peak_ff, peak_in;
   logic [62:0]        jit_ff, jit_in;
   logic [31:0]        cnt_ff, cnt_in;
   logic [62:0]        target;
   logic signed [63:0] jdiff, jstep;
   logic [63:0]        jsum;
   stat_type           snp_ff, snp_in;

   always_comb begin
      // arithmetic shift floors the step in both directions
      target = {sat_ff.mag, 16'd0};
      jdiff  = $signed({1'b0, target}) - $signed({1'b0, jit_ff});
      jstep  = jdiff >>> gain_ff;
      jsum   = {1'b0, jit_ff} + unsigned'(jstep);

      delta_in = delta_ff;
      peak_in  = peak_ff;
      jit_in   = jit_ff;
      cnt_in   = cnt_ff;
      unique case (sat_ff.act)
         ACT_DIFF: begin
            delta_in = sat_ff.delta;
            peak_in  = (sat_ff.mag > peak_ff) ? sat_ff.mag : peak_ff;
            jit_in   = jsum[62:0];
            cnt_in   = cnt_ff + 32'd1;
         end
         ACT_CLEAR: begin
            delta_in = '0;
            peak_in  = '0;
            jit_in   = '0;
            cnt_in   = '0;
         end
         default: begin
         end
      endcase

      snp_in.anchored = sat_ff.anchored;
      snp_in.delta    = delta_in;
      snp_in.peak     = peak_in;
      snp_in.jitter   = jit_in;
      snp_in.count    = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= '0;
         peak_ff  <= '0;
         jit_ff   <= '0;
         cnt_ff   <= '0;
      end else if (xfer[STG_SNP]) begin
         delta_ff <= delta_in;
         peak_ff  <= peak_in;
         jit_ff   <= jit_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer[STG_SNP]) snp_ff <= snp_in;
   end

   // ---------------------------------------------------------------------
   // Jitter in microseconds Q8: floor((jitter * 125 >> 9) / 3)
   // ---------------------------------------------------------------------
   out_stage_type out_ff [0:NUM_DIGITS];
   out_stage_type out_in [0:NUM_DIGITS];
   logic [69:0]   jit_x125;

   always_comb begin
      // 125 * j as 128 * j - 4 * j + j
      jit_x125 = {snp_ff.jitter, 7'd0} - {5'd0, snp_ff.jitter, 2'd0} +
                 {7'd0, snp_ff.jitter};
      out_in[0].stat = snp_ff;
      out_in[0].word = {3'd0, jit_x125[69:9]};
      out_in[0].rem  = '0;
   end

   always_ff @(posedge clock) begin
      if (xfer[STG_OUT0]) out_ff[0] <= out_in[0];
   end

   for (genvar j = 1; j <= NUM_DIGITS; j++) begin : g_out
      localparam int unsigned DIG = NUM_DIGITS - j;
      d3_type step;

      always_comb begin
         step = div3_step(out_ff[j-1].rem, out_ff[j-1].word[DIG*DIGIT_W +: DIGIT_W]);
         out_in[j] = out_ff[j-1];
         out_in[j].word[DIG*DIGIT_W +: DIGIT_W] = step.quo;
         out_in[j].rem = step.rem;
      end

      always_ff @(posedge clock) begin
         if (xfer[STG_OUT0+j]) out_ff[j] <= out_in[j];
      end
   end

   // ---------------------------------------------------------------------
   // Result item
   // ---------------------------------------------------------------------
   assign rsp_valid                   = valid_ff[NSTG-1];
   assign rsp_data.is_anchored        = out_ff[NUM_DIGITS].stat.anchored;
   assign rsp_data.last_transit_delta = out_ff[NUM_DIGITS].stat.delta;
   assign rsp_data.peak_abs_delta     = out_ff[NUM_DIGITS].stat.peak;
   assign rsp_data.jitter_samples_q16 = out_ff[NUM_DIGITS].stat.jitter;
   assign rsp_data.jitter_us_q8       = out_ff[NUM_DIGITS].word[61:0];
   assign rsp_data.sample_count       = out_ff[NUM_DIGITS].stat.count;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // input is held off only when every stage holds an item
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> &valid_ff)
      else $error("input stalled with a bubble in the pipeline");

   // peak only drops on a clear
   a_peak_mono: assert property (@(posedge clock) disable iff (reset)
      (xfer[STG_SNP] && sat_ff.act != ACT_CLEAR) |=> peak_ff >= $past(peak_ff))
      else $error("peak decreased without clear");

   // each averaged difference bumps the count by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (xfer[STG_SNP] && sat_ff.act == ACT_DIFF) |=>
         cnt_ff == 32'($past(cnt_ff) + 32'd1))
      else $error("sample count did not advance");

   // a clear item drops the anchor
   a_clear_anchor: assert property (@(posedge clock) disable iff (reset)
      (xfer[STG_DLT] && cnv_ff[NUM_DIGITS].mode == MODE_CLEAR) |=> !anchored_ff)
      else $error("anchor survived a clear");

endmodule
